// File: sv/exchange_sort_by_key_macros.svh
// Assertion macros for the exchange sort block
`ifndef EXCHANGE_SORT_BY_KEY_MACROS_SVH
`define EXCHANGE_SORT_BY_KEY_MACROS_SVH

// same-cycle implication
`define ESBK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("exchange sort: same-cycle check failed");

// next-cycle implication
`define ESBK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("exchange sort: next-cycle check failed");

`endif

// File: sv/esbk_pkg.sv
`default_nettype none
package esbk_pkg;

  localparam int QTY_W = 24;
  localparam int TAG_W = 6;

  typedef struct packed {
    logic [QTY_W-1:0] quantity;
    logic [TAG_W-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic vld;
    logic fin;
    logic ovf;
  } emit_t;

endpackage
`default_nettype wire

// File: sv/esbk_mem.sv
`default_nettype none
module esbk_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 30
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: sv/esbk_ctrl.sv
`default_nettype none
module esbk_ctrl import esbk_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  parameter int ADDR_W      = 6,
  parameter int CNT_W       = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire rec_t              in_rec,
  input  wire logic              in_last,
  output logic                   busy,
  output logic                   mem_we,
  output logic      [ADDR_W-1:0] mem_waddr,
  output rec_t                   mem_wdata,
  output logic      [ADDR_W-1:0] mem_raddr,
  input  wire rec_t              mem_rdata,
  output emit_t                  emit
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADA,
    S_FIRST,
    S_CMP,
    S_WBA,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              drop_r, drop_nxt;
  logic [ADDR_W-1:0] a_r, a_nxt;
  logic [ADDR_W-1:0] b_r, b_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  rec_t              cur_r, cur_nxt;
  logic [CNT_W-1:0]  last_cnt;
  logic [ADDR_W-1:0] last_a;
  logic              full;

  assign last_cnt = cnt_r - CNT_W'(1);
  assign last_a   = last_cnt[ADDR_W-1:0];
  assign full     = (cnt_r >= CNT_W'(MAX_RECORDS));
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    mem_we    = 1'b0;
    mem_waddr = a_r;
    mem_wdata = cur_r;
    mem_raddr = a_r;
    emit      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!full) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[ADDR_W-1:0];
            mem_wdata = in_rec;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            a_nxt = '0;
            k_nxt = '0;
            if (cnt_nxt > CNT_W'(1)) begin
              state_nxt = S_LOADA;
            end else begin
              state_nxt = S_EMIT_RD;
            end
          end
        end
      end
      S_LOADA: begin
        mem_raddr = a_r;
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        cur_nxt   = mem_rdata;
        mem_raddr = a_r + ADDR_W'(1);
        b_nxt     = a_r + ADDR_W'(1);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        mem_raddr = (b_r == last_a) ? a_r : b_r + ADDR_W'(1);
        if (cur_r.quantity > mem_rdata.quantity) begin
          mem_we    = 1'b1;
          mem_waddr = b_r;
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
        end
        b_nxt = b_r + ADDR_W'(1);
        if (b_r == last_a) begin
          state_nxt = S_WBA;
        end
      end
      S_WBA: begin
        mem_we    = 1'b1;
        mem_waddr = a_r;
        mem_wdata = cur_r;
        mem_raddr = a_r + ADDR_W'(1);
        a_nxt     = a_r + ADDR_W'(1);
        if (a_r + ADDR_W'(1) == last_a) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          state_nxt = S_FIRST;
        end
      end
      S_EMIT_RD: begin
        mem_raddr = k_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        emit.vld  = 1'b1;
        emit.fin  = (k_r == last_a);
        emit.ovf  = drop_r;
        mem_raddr = (k_r == last_a) ? k_r : k_r + ADDR_W'(1);
        k_nxt     = k_r + ADDR_W'(1);
        if (k_r == last_a) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
  end

endmodule
`default_nettype wire

// File: sv/exchange_sort_by_key.sv
`default_nettype none
// Collects up to MAX_RECORDS records (24-bit quantity key, 6-bit tag) into one
// record RAM, one per start transaction, each taken while busy is low. The
// transaction with in_last_item set closes the list; busy then rises while the
// records are exchange-sorted ascending by key (ties kept in the order the
// classic i/j exchange loop leaves them) and emitted. The RAM has one read and
// one write port, so the sort does one key compare per cycle. Results appear
// back to back, one per cycle with out_strobe high, and cannot be held off:
// the receiver must take each in the cycle it is shown. out_final_result marks
// the last one, and out_overflow_seen is set on all results of a list that lost
// records to a full store. A new list may start as soon as busy falls.
module exchange_sort_by_key import esbk_pkg::*; #(
  parameter int MAX_RECORDS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [QTY_W-1:0] in_item_quantity,
  input  wire logic [TAG_W-1:0] in_item_tag,
  input  wire logic             in_last_item,
  output logic                  out_strobe,
  output logic      [QTY_W-1:0] out_sorted_quantity,
  output logic      [TAG_W-1:0] out_sorted_tag,
  output logic                  out_final_result,
  output logic                  out_overflow_seen
);

  localparam int ADDR_W = $clog2(MAX_RECORDS);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

  rec_t              in_rec;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  rec_t              mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  rec_t              mem_rdata;
  emit_t             emit;

  logic              strobe_r;
  logic [QTY_W-1:0]  qty_r;
  logic [TAG_W-1:0]  tag_r;
  logic              fin_r;
  logic              ovf_r;

  assign in_rec.quantity = in_item_quantity;
  assign in_rec.tag      = in_item_tag;

  esbk_ctrl #(
    .MAX_RECORDS (MAX_RECORDS),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_rec    (in_rec),
    .in_last   (in_last_item),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .emit      (emit)
  );

  esbk_mem #(
    .DEPTH  (MAX_RECORDS),
    .ADDR_W (ADDR_W),
    .DATA_W ($bits(rec_t))
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= emit.vld;
    end
    if (emit.vld) begin
      qty_r <= mem_rdata.quantity;
      tag_r <= mem_rdata.tag;
      fin_r <= emit.fin;
      ovf_r <= emit.ovf;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_sorted_quantity = qty_r;
  assign out_sorted_tag      = tag_r;
  assign out_final_result    = fin_r;
  assign out_overflow_seen   = ovf_r;

endmodule
`default_nettype wire

// File: sv/esbk_chk.sv
`default_nettype none
`include "exchange_sort_by_key_macros.svh"
module esbk_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_last_item,
  input wire logic out_strobe,
  input wire logic out_final_result,
  input wire logic out_overflow_seen
);

  // a record that does not close the list leaves busy low in the next cycle
  `ESBK_NEXT(a_load_one_cycle, start && !busy && !in_last_item, !busy)
  // closing transaction always starts the sort or emit phase
  `ESBK_NEXT(a_close_goes_busy, start && !busy && in_last_item, busy)
  // results of one list come back to back with a constant overflow flag
  `ESBK_NEXT(a_results_contiguous, out_strobe && !out_final_result,
             out_strobe && (out_overflow_seen == $past(out_overflow_seen)))
  // no result but the last is shown once busy has dropped
  `ESBK_IMPLY(a_result_while_busy, out_strobe && !out_final_result, busy)

endmodule

bind exchange_sort_by_key esbk_chk u_esbk_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_last_item      (in_last_item),
  .out_strobe        (out_strobe),
  .out_final_result  (out_final_result),
  .out_overflow_seen (out_overflow_seen)
);
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
module tb;
  import esbk_pkg::*;

  localparam int MAX_RECORDS = 64;
  localparam int ITEM_TARGET = 425;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    rec_t rec;
    bit   last;
    bit   drain;
    int   gap;
  } feed_item_t;

  typedef struct {
    rec_t rec;
    bit   fin;
    bit   ovf;
  } sorted_rec_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [QTY_W-1:0] in_item_quantity = '0;
  logic [TAG_W-1:0] in_item_tag = '0;
  logic             in_last_item = 1'b0;
  logic             busy;
  logic             out_strobe;
  logic [QTY_W-1:0] out_sorted_quantity;
  logic [TAG_W-1:0] out_sorted_tag;
  logic             out_final_result;
  logic             out_overflow_seen;

  feed_item_t  record_feed[$];
  sorted_rec_t sorted_due[$];
  rec_t        list_mem[MAX_RECORDS];
  int          list_len = 0;
  bit          list_dropped = 1'b0;

  feed_item_t  next_item;
  sorted_rec_t due_head;
  bit          taken = 1'b0;
  int          gap_left = 0;
  int          stall_cycles = 0;
  int          errors = 0;
  int          records_taken = 0;
  int          results_seen = 0;
  int          lists_closed = 0;
  int          lists_overflowed = 0;

  exchange_sort_by_key #(
    .MAX_RECORDS(MAX_RECORDS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_item_quantity    (in_item_quantity),
    .in_item_tag         (in_item_tag),
    .in_last_item        (in_last_item),
    .out_strobe          (out_strobe),
    .out_sorted_quantity (out_sorted_quantity),
    .out_sorted_tag      (out_sorted_tag),
    .out_final_result    (out_final_result),
    .out_overflow_seen   (out_overflow_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic add_record(input int unsigned q, input int unsigned t, input bit last,
                            input bit drain, input int gap);
    feed_item_t f;
    f.rec.quantity = q[QTY_W-1:0];
    f.rec.tag      = t[TAG_W-1:0];
    f.last         = last;
    f.drain        = drain;
    f.gap          = gap;
    record_feed.push_back(f);
  endtask

  // store one record; on the closing one, exchange-sort and queue the sorted list
  task automatic absorb_record(input rec_t r, input bit last);
    rec_t        tmp;
    sorted_rec_t s;
    if (list_len < MAX_RECORDS) begin
      list_mem[list_len] = r;
      list_len++;
    end else begin
      list_dropped = 1'b1;
    end
    if (last) begin
      for (int a = 0; a + 1 < list_len; a++) begin
        for (int b = a + 1; b < list_len; b++) begin
          if (list_mem[a].quantity > list_mem[b].quantity) begin
            tmp         = list_mem[a];
            list_mem[a] = list_mem[b];
            list_mem[b] = tmp;
          end
        end
      end
      for (int k = 0; k < list_len; k++) begin
        s.rec = list_mem[k];
        s.fin = (k + 1 == list_len);
        s.ovf = list_dropped;
        sorted_due.push_back(s);
      end
      lists_closed++;
      if (list_dropped) lists_overflowed++;
      list_len     = 0;
      list_dropped = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (record_feed.size() != 0 &&
                   !(record_feed[0].drain && sorted_due.size() != 0)) begin
        next_item        = record_feed.pop_front();
        in_item_quantity <= next_item.rec.quantity;
        in_item_tag      <= next_item.rec.tag;
        in_last_item     <= next_item.last;
        start            <= 1'b1;
        gap_left         <= next_item.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (out_strobe) begin
        results_seen++;
        if (sorted_due.size() == 0) begin
          $error("result transaction with nothing outstanding");
          errors++;
        end else begin
          due_head = sorted_due.pop_front();
          check_field("sorted_quantity", 32'(due_head.rec.quantity), 32'(out_sorted_quantity));
          check_field("sorted_tag", 32'(due_head.rec.tag), 32'(out_sorted_tag));
          check_field("final_result", 32'(due_head.fin), 32'(out_final_result));
          check_field("overflow_seen", 32'(due_head.ovf), 32'(out_overflow_seen));
        end
      end
      if (start && !busy) begin
        absorb_record('{quantity: in_item_quantity, tag: in_item_tag}, in_last_item);
        records_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("exchange_sort_by_key: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int          list_no;
    int          rand_fed;
    int          len;
    int          mode;
    int          pick;
    bit          paced;
    bit          drain;
    int unsigned q;

    // single record, all ones
    add_record(32'hFFFFFF, 63, 1'b1, 1'b0, 0);
    // two records, reversed extremes
    add_record(32'hFFFFFF, 0, 1'b0, 1'b0, 0);
    add_record(32'h000000, 63, 1'b1, 1'b0, 3);
    // equal keys, tie order
    add_record(5, 1, 1'b0, 1'b0, 0);
    add_record(3, 2, 1'b0, 1'b0, 1);
    add_record(5, 3, 1'b0, 1'b0, 0);
    add_record(3, 4, 1'b0, 1'b0, 2);
    add_record(5, 5, 1'b1, 1'b0, 0);
    // descending
    add_record(32'hFFFFFF, 10, 1'b0, 1'b0, 0);
    add_record(32'h800000, 11, 1'b0, 1'b0, 0);
    add_record(32'h7FFFFF, 12, 1'b0, 1'b0, 0);
    add_record(1, 13, 1'b0, 1'b0, 0);
    add_record(0, 14, 1'b1, 1'b0, 0);
    // already ascending
    add_record(0, 20, 1'b0, 1'b0, 0);
    add_record(1, 21, 1'b0, 1'b0, 0);
    add_record(2, 22, 1'b0, 1'b0, 0);
    add_record(3, 23, 1'b1, 1'b0, 5);
    // all keys equal
    add_record(32'h123456, 40, 1'b0, 1'b0, 0);
    add_record(32'h123456, 41, 1'b0, 1'b0, 0);
    add_record(32'h123456, 42, 1'b1, 1'b0, 0);

    list_no  = 0;
    rand_fed = 0;
    while (rand_fed < ITEM_TARGET) begin
      case (list_no)
        0: len = MAX_RECORDS;
        1: len = MAX_RECORDS + 3;
        2: len = MAX_RECORDS + 1;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 14) len = $urandom_range(1, 8);
          else if (pick < 19) len = $urandom_range(9, 20);
          else len = $urandom_range(MAX_RECORDS - 4, MAX_RECORDS + 6);
        end
      endcase
      mode  = $urandom_range(0, 3);
      paced = ($urandom_range(0, 3) != 0);
      drain = (list_no == 3) || ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: q = $urandom;
          1: q = $urandom_range(0, 7);
          2: begin
            pick = $urandom_range(0, 3);
            q = (pick == 0) ? 32'h000000 : (pick == 1) ? 32'hFFFFFF :
                (pick == 2) ? 32'h800000 : 32'h7FFFFF;
          end
          default: q = $urandom_range(0, 255) << $urandom_range(0, 16);
        endcase
        add_record(q, $urandom, k == len - 1, drain && k == 0,
                   paced ? $urandom_range(0, 9) : 0);
      end
      list_no++;
      rand_fed += len;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (record_feed.size() != 0 || start) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d records in %0d lists sorted, %0d results checked", records_taken,
             lists_closed, results_seen);
    $display("%0d lists lost records to a full store; ties, extremes and paced gaps included",
             lists_overflowed);
    if (errors == 0) begin
      $display("exchange_sort_by_key: match");
    end else begin
      $display("exchange_sort_by_key: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/esbk_pkg.sv
sv/esbk_mem.sv
sv/esbk_ctrl.sv
sv/exchange_sort_by_key.sv
sv/esbk_chk.sv
bench/tb.sv
